// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("reset check failed");

`endif

// ===== sv/mrc_pkg.sv =====
// Shared types, constants and step functions of the diversity combiner.
`timescale 1ns / 1ps
package mrc_pkg;

  localparam int BRANCHES = 4;
  localparam logic [15:0] CONF_ONE = 16'h8000;
  localparam logic [31:0] SNR_ONE = 32'h0001_0000;
  localparam logic [2:0] BRANCHES_RESET = 3'd2;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_BRANCHES = 3'd0;
  localparam logic [2:0] REG_SNR_B0 = 3'd1;

  localparam int LAT_BITS = 16;
  localparam int CONF_BITS = 30;
  localparam int DIV_STAGES = 8;
  localparam int LAT_SPS = LAT_BITS / DIV_STAGES;
  localparam int CONF_SPS = (CONF_BITS + DIV_STAGES - 1) / DIV_STAGES;
  localparam int ROOT_BITS = 15;
  localparam int SQRT_STAGES = 4;
  localparam int SQRT_SPS = (ROOT_BITS + SQRT_STAGES - 1) / SQRT_STAGES;

  typedef logic [BRANCHES-1:0][31:0] snr_arr_t;
  typedef logic [BRANCHES-1:0][15:0] word_arr_t;

  typedef struct packed {
    logic        bypass;
    logic        zero;
    logic        cap;
    logic        neg;
    logic [15:0] lat0;
    logic [15:0] conf0;
    logic [45:0] lrem;
    logic [15:0] lbits;
    logic [15:0] lq;
    logic [45:0] den;
    logic [31:0] crem;
    logic [29:0] cbits;
    logic [29:0] cq;
    logic [31:0] refsnr;
  } div_t;

  typedef struct packed {
    logic        bypass;
    logic        zero;
    logic        cap;
    logic [15:0] lat;
    logic [15:0] conf0;
    logic [16:0] srem;
    logic [14:0] root;
    logic [29:0] sbits;
  } root_t;

  function automatic logic [15:0] cap_conf(logic [15:0] c);
    return (c > CONF_ONE) ? CONF_ONE : c;
  endfunction

  // Restoring division steps of one stage for both quotients.
  function automatic div_t div_stage(div_t d, int stage);
    div_t r;
    logic [46:0] lt;
    logic [32:0] ct;
    r = d;
    for (int k = 0; k < LAT_SPS; k++) begin
      lt = {r.lrem, r.lbits[15]};
      r.lbits = {r.lbits[14:0], 1'b0};
      if (lt >= {1'b0, r.den}) begin
        lt = lt - {1'b0, r.den};
        r.lq = {r.lq[14:0], 1'b1};
      end else begin
        r.lq = {r.lq[14:0], 1'b0};
      end
      r.lrem = lt[45:0];
    end
    for (int k = 0; k < CONF_SPS; k++) begin
      if (stage * CONF_SPS + k < CONF_BITS) begin
        ct = {r.crem, r.cbits[29]};
        r.cbits = {r.cbits[28:0], 1'b0};
        if (ct >= {1'b0, r.refsnr}) begin
          ct = ct - {1'b0, r.refsnr};
          r.cq = {r.cq[28:0], 1'b1};
        end else begin
          r.cq = {r.cq[28:0], 1'b0};
        end
        r.crem = ct[31:0];
      end
    end
    return r;
  endfunction

  // Digit-by-digit square root steps of one stage.
  function automatic root_t sqrt_stage(root_t d, int stage);
    root_t r;
    logic [18:0] t;
    logic [18:0] trial;
    r = d;
    for (int k = 0; k < SQRT_SPS; k++) begin
      if (stage * SQRT_SPS + k < ROOT_BITS) begin
        t = {r.srem, r.sbits[29:28]};
        r.sbits = {r.sbits[27:0], 2'b00};
        trial = {2'b00, r.root, 2'b01};
        if (t >= trial) begin
          t = t - trial;
          r.root = {r.root[13:0], 1'b1};
        end else begin
          r.root = {r.root[13:0], 1'b0};
        end
        r.srem = t[16:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/mrc_front.sv =====
// Weight, product and sum stages feeding the dividers.
`timescale 1ns / 1ps
module mrc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrc_pkg::word_arr_t  lat,
  input  mrc_pkg::word_arr_t  conf,
  input  logic [2:0]          branches_in_use,
  input  mrc_pkg::snr_arr_t   snr_lin,
  output logic                out_valid,
  input  logic                out_ready,
  output mrc_pkg::div_t       out_data
);

  localparam int NB = mrc_pkg::BRANCHES;

  logic [4:0] v;
  logic [5:0] rdy;

  // stage 1
  logic              s1_bypass;
  logic [15:0]       s1_lat0;
  logic [15:0]       s1_conf0;
  mrc_pkg::snr_arr_t s1_snr;
  logic [NB-1:0][30:0] s1_c2;
  mrc_pkg::word_arr_t s1_lat;
  // stage 2
  logic              s2_bypass;
  logic [15:0]       s2_lat0;
  logic [15:0]       s2_conf0;
  logic [NB-1:0][43:0] s2_w;
  logic [31:0]       s2_ref;
  mrc_pkg::word_arr_t s2_lat;
  // stage 3
  logic              s3_bypass;
  logic [15:0]       s3_lat0;
  logic [15:0]       s3_conf0;
  logic signed [NB-1:0][60:0] s3_p;
  logic [45:0]       s3_den;
  logic [31:0]       s3_ref;
  // stage 4
  logic              s4_bypass;
  logic [15:0]       s4_lat0;
  logic [15:0]       s4_conf0;
  logic signed [62:0] s4_num;
  logic [45:0]       s4_den;
  logic [31:0]       s4_ref;
  logic              s4_zero;
  logic              s4_cap;

  // stage 1 inputs
  logic [2:0]        n_eff;
  logic              any_snr;
  mrc_pkg::snr_arr_t snr_eff;
  logic [NB-1:0][15:0] conf_cap;

  always_comb begin
    if (branches_in_use == 3'd0) begin
      n_eff = 3'd1;
    end else if (branches_in_use > 3'(NB)) begin
      n_eff = 3'(NB);
    end else begin
      n_eff = branches_in_use;
    end
    any_snr = 1'b0;
    for (int i = 0; i < NB; i++) begin
      if ((3'(i) < n_eff) && (snr_lin[i] != 32'd0)) begin
        any_snr = 1'b1;
      end
    end
    for (int i = 0; i < NB; i++) begin
      conf_cap[i] = mrc_pkg::cap_conf(conf[i]);
      if (3'(i) < n_eff) begin
        snr_eff[i] = any_snr ? snr_lin[i] : mrc_pkg::SNR_ONE;
      end else begin
        snr_eff[i] = 32'd0;
      end
    end
  end

  // stage 2/3/4/5 combinational pieces
  logic [31:0]       ref_max;
  logic [45:0]       den_sum;
  logic signed [62:0] num_sum;
  logic [61:0]       mag;
  logic [61:0]       xdiv;

  always_comb begin
    ref_max = 32'd0;
    for (int i = 0; i < NB; i++) begin
      if (s1_snr[i] > ref_max) begin
        ref_max = s1_snr[i];
      end
    end
    den_sum = 46'd0;
    for (int i = 0; i < NB; i++) begin
      den_sum = den_sum + 46'(s2_w[i]);
    end
    num_sum = 63'sd0;
    for (int i = 0; i < NB; i++) begin
      num_sum = num_sum + 63'($signed(s3_p[i]));
    end
    mag = s4_num[62] ? 62'(-s4_num) : 62'(s4_num);
    xdiv = mag + 62'(s4_den[45:1]);
  end

  assign rdy[5] = out_ready;
  for (genvar s = 0; s < 5; s++) begin : g_rdy
    assign rdy[s] = !v[s] || rdy[s+1];
  end
  assign in_ready = rdy[0];
  assign out_valid = v[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int s = 1; s < 5; s++) begin
        if (rdy[s]) v[s] <= v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_bypass <= (n_eff == 3'd1);
      s1_lat0 <= lat[0];
      s1_conf0 <= conf_cap[0];
      s1_snr <= snr_eff;
      s1_lat <= lat;
      for (int i = 0; i < NB; i++) begin
        s1_c2[i] <= 31'(conf_cap[i]) * 31'(conf_cap[i]);
      end
    end
    if (rdy[1]) begin
      s2_bypass <= s1_bypass;
      s2_lat0 <= s1_lat0;
      s2_conf0 <= s1_conf0;
      s2_ref <= ref_max;
      s2_lat <= s1_lat;
      for (int i = 0; i < NB; i++) begin
        s2_w[i] <= 44'((63'(s1_snr[i]) * 63'(s1_c2[i])) >> 18);
      end
    end
    if (rdy[2]) begin
      s3_bypass <= s2_bypass;
      s3_lat0 <= s2_lat0;
      s3_conf0 <= s2_conf0;
      s3_den <= den_sum;
      s3_ref <= s2_ref;
      for (int i = 0; i < NB; i++) begin
        s3_p[i] <= 61'($signed({1'b0, s2_w[i]})) * 61'($signed(s2_lat[i]));
      end
    end
    if (rdy[3]) begin
      s4_bypass <= s3_bypass;
      s4_lat0 <= s3_lat0;
      s4_conf0 <= s3_conf0;
      s4_num <= num_sum;
      s4_den <= s3_den;
      s4_ref <= s3_ref;
      s4_zero <= (s3_den == 46'd0);
      s4_cap <= (s3_den >= {2'b00, s3_ref, 12'd0});
    end
    if (rdy[4]) begin
      out_data.bypass <= s4_bypass;
      out_data.zero <= s4_zero;
      out_data.cap <= s4_cap;
      out_data.neg <= s4_num[62];
      out_data.lat0 <= s4_lat0;
      out_data.conf0 <= s4_conf0;
      out_data.lrem <= xdiv[61:16];
      out_data.lbits <= xdiv[15:0];
      out_data.lq <= 16'd0;
      out_data.den <= s4_den;
      out_data.crem <= s4_den[43:12];
      out_data.cbits <= {s4_den[11:0], 18'd0};
      out_data.cq <= 30'd0;
      out_data.refsnr <= s4_ref;
    end
  end

endmodule

// ===== sv/mrc_divide.sv =====
// Pipelined restoring dividers for the weighted mean and the confidence ratio.
`timescale 1ns / 1ps
module mrc_divide (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mrc_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mrc_pkg::div_t out_data
);

  localparam int S = mrc_pkg::DIV_STAGES;

  logic [S-1:0]  v;
  logic [S:0]    rdy;
  mrc_pkg::div_t d [S];

  assign rdy[S] = out_ready;
  for (genvar s = 0; s < S; s++) begin : g_stage
    assign rdy[s] = !v[s] || rdy[s+1];
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rdy[s]) d[s] <= mrc_pkg::div_stage(in_data, s);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rdy[s]) d[s] <= mrc_pkg::div_stage(d[s-1], s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int s = 1; s < S; s++) begin
        if (rdy[s]) v[s] <= v[s-1];
      end
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = v[S-1];
  assign out_data = d[S-1];

endmodule

// ===== sv/mrc_sqrt.sv =====
// Latent saturation, square root and result selection from the last stage register.
`timescale 1ns / 1ps
module mrc_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mrc_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic signed [15:0] combined_latent,
  output logic [15:0]   combined_conf,
  output logic          no_weight
);

  localparam int S = mrc_pkg::SQRT_STAGES;

  logic [S-1:0]   v;
  logic [S:0]     rdy;
  mrc_pkg::root_t d [S];
  mrc_pkg::root_t entry;
  logic [15:0]    q;

  always_comb begin
    q = in_data.lq;
    entry.bypass = in_data.bypass;
    entry.zero = in_data.zero;
    entry.cap = in_data.cap;
    entry.conf0 = in_data.conf0;
    entry.srem = 17'd0;
    entry.root = 15'd0;
    entry.sbits = in_data.cq;
    if (in_data.bypass) begin
      entry.lat = in_data.lat0;
    end else if (in_data.zero) begin
      entry.lat = 16'd0;
    end else if (in_data.neg) begin
      entry.lat = (q > 16'h8000) ? 16'h8000 : 16'(-q);
    end else begin
      entry.lat = (q > 16'h7FFF) ? 16'h7FFF : q;
    end
  end

  assign rdy[S] = out_ready;
  for (genvar s = 0; s < S; s++) begin : g_stage
    assign rdy[s] = !v[s] || rdy[s+1];
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rdy[s]) d[s] <= mrc_pkg::sqrt_stage(entry, s);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rdy[s]) d[s] <= mrc_pkg::sqrt_stage(d[s-1], s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int s = 1; s < S; s++) begin
        if (rdy[s]) v[s] <= v[s-1];
      end
    end
  end

  always_comb begin
    combined_latent = $signed(d[S-1].lat);
    no_weight = !d[S-1].bypass && d[S-1].zero;
    if (d[S-1].bypass) begin
      combined_conf = d[S-1].conf0;
    end else if (d[S-1].zero) begin
      combined_conf = 16'd0;
    end else if (d[S-1].cap) begin
      combined_conf = mrc_pkg::CONF_ONE;
    end else begin
      combined_conf = {1'b0, d[S-1].root};
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = v[S-1];

endmodule

// ===== sv/mrc_diversity_combiner_top.sv =====
// Maximal-ratio diversity combiner, top level.
// Pipeline: 17 register stages (5 weight/sum, 8 divider, 4 square-root); the last one
// is the output register.
// Throughput: one item per cycle while out_ready is high; each stage advances on its own when the next is free.
// Reset: synchronous; clears all stage valid bits, sets branches_in_use to 2 and all SNRs to one.
`timescale 1ns / 1ps
module mrc_diversity_combiner_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] lat_b0,
  input  logic signed [15:0] lat_b1,
  input  logic signed [15:0] lat_b2,
  input  logic signed [15:0] lat_b3,
  input  logic [15:0]        conf_b0,
  input  logic [15:0]        conf_b1,
  input  logic [15:0]        conf_b2,
  input  logic [15:0]        conf_b3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] combined_latent,
  output logic [15:0]        combined_conf,
  output logic               no_weight,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [2:0]         branches_in_use;
  mrc_pkg::snr_arr_t  snr_lin;
  mrc_pkg::word_arr_t lat;
  mrc_pkg::word_arr_t conf;
  mrc_pkg::div_t      front_data;
  mrc_pkg::div_t      div_data;
  logic               front_valid;
  logic               front_ready;
  logic               div_valid;
  logic               div_ready;

  assign cfg_ready = 1'b1;
  assign lat = {lat_b3, lat_b2, lat_b1, lat_b0};
  assign conf = {conf_b3, conf_b2, conf_b1, conf_b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      branches_in_use <= mrc_pkg::BRANCHES_RESET;
      for (int i = 0; i < mrc_pkg::BRANCHES; i++) begin
        snr_lin[i] <= mrc_pkg::SNR_ONE;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == mrc_pkg::REG_BRANCHES) begin
        branches_in_use <= cfg_data[2:0];
      end
      for (int i = 0; i < mrc_pkg::BRANCHES; i++) begin
        if (cfg_index == mrc_pkg::REG_SNR_B0 + 3'(i)) begin
          snr_lin[i] <= cfg_data;
        end
      end
    end
  end

  mrc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .lat             (lat),
    .conf            (conf),
    .branches_in_use (branches_in_use),
    .snr_lin         (snr_lin),
    .out_valid       (front_valid),
    .out_ready       (front_ready),
    .out_data        (front_data)
  );

  mrc_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  mrc_sqrt u_sqrt (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (div_valid),
    .in_ready        (div_ready),
    .in_data         (div_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .combined_latent (combined_latent),
    .combined_conf   (combined_conf),
    .no_weight       (no_weight)
  );

endmodule

// ===== sv/mrc_checker.sv =====
// Port-level checker for the combiner, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mrc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] combined_latent,
  input logic [15:0]        combined_conf,
  input logic               no_weight
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPLY(a_conf_cap, clk, rst, out_valid, combined_conf <= 16'h8000)
  `ASSERT_IMPLY(a_zero_out, clk, rst, out_valid && no_weight, {combined_latent, combined_conf} == 0)
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind mrc_diversity_combiner_top mrc_checker u_mrc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .combined_latent (combined_latent),
  .combined_conf   (combined_conf),
  .no_weight       (no_weight)
);

// ===== dv/tb_mrc_diversity_combiner_top.sv =====
// Testbench for the diversity combiner: random and directed symbols checked against a predictor.
`timescale 1ns / 1ps
module tb_mrc_diversity_combiner_top;

  typedef struct packed {
    logic signed [15:0] lat;
    logic [15:0]        conf;
    logic               nw;
  } combined_t;

  class combine_scoreboard;
    combined_t pending[$];
    int errors;
    logic [2:0]  lanes;
    logic [31:0] snr[mrc_pkg::BRANCHES];

    function void init();
      lanes = mrc_pkg::BRANCHES_RESET;
      for (int i = 0; i < mrc_pkg::BRANCHES; i++) snr[i] = mrc_pkg::SNR_ONE;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      if (idx == mrc_pkg::REG_BRANCHES) lanes = d[2:0];
      else if (idx <= mrc_pkg::BRANCHES) snr[idx - mrc_pkg::REG_SNR_B0] = d;
    endfunction

    function void note_symbol(mrc_pkg::word_arr_t lat, mrc_pkg::word_arr_t conf);
      combined_t e;
      int n;
      logic [31:0] s[mrc_pkg::BRANCHES];
      logic [31:0] refsnr;
      logic [63:0] den, w, c, mag, q, rad, root, bitv;
      logic signed [63:0] num;
      bit any;
      n = (lanes == 0) ? 1 : (lanes > mrc_pkg::BRANCHES ? mrc_pkg::BRANCHES : lanes);
      e = '0;
      if (n == 1) begin
        e.lat = lat[0];
        e.conf = (conf[0] > mrc_pkg::CONF_ONE) ? mrc_pkg::CONF_ONE : conf[0];
        pending = {pending, e};
        return;
      end
      any = 0;
      for (int i = 0; i < n; i++) if (snr[i] != 0) any = 1;
      den = 0; num = 0; refsnr = 0;
      for (int i = 0; i < n; i++) begin
        s[i] = any ? snr[i] : mrc_pkg::SNR_ONE;
        if (s[i] > refsnr) refsnr = s[i];
        c = (conf[i] > mrc_pkg::CONF_ONE) ? mrc_pkg::CONF_ONE : conf[i];
        w = (64'(s[i]) * (c * c)) >> 18;
        den += w;
        num += $signed(w) * 64'($signed(lat[i]));
      end
      if (den == 0) begin
        e.nw = 1;
      end else begin
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (num < 0) e.lat = (q > 32768) ? 16'h8000 : 16'(-q);
        else e.lat = (q > 32767) ? 16'h7fff : 16'(q);
        if (den >= (64'(refsnr) << 12)) e.conf = mrc_pkg::CONF_ONE;
        else begin
          rad = (den << 18) / refsnr;
          root = 0;
          for (int b = 31; b >= 0; b--) begin
            bitv = root | (64'd1 << b);
            if (bitv * bitv <= rad) root = bitv;
          end
          e.conf = (root > mrc_pkg::CONF_ONE) ? mrc_pkg::CONF_ONE : root[15:0];
        end
      end
      pending = {pending, e};
    endfunction

    function void check_result(combined_t got);
      combined_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result lat=%0d conf=%0d nw=%0b", $time,
                 got.lat, got.conf, got.nw);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.lat !== e.lat) begin
        $display("%0t: combined_latent expected %0d actual %0d", $time, e.lat, got.lat);
        errors++;
      end
      if (got.conf !== e.conf) begin
        $display("%0t: combined_conf expected %0d actual %0d", $time, e.conf, got.conf);
        errors++;
      end
      if (got.nw !== e.nw) begin
        $display("%0t: no_weight expected %0b actual %0b", $time, e.nw, got.nw);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [15:0] lat_b0 = 0, lat_b1 = 0, lat_b2 = 0, lat_b3 = 0;
  logic [15:0] conf_b0 = 0, conf_b1 = 0, conf_b2 = 0, conf_b3 = 0;
  logic signed [15:0] combined_latent;
  logic [15:0] combined_conf;
  logic no_weight;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  bit quiet = 0;
  int n_symbols = 0, n_results = 0, n_writes = 0;

  combine_scoreboard sb;

  always #6 clk = ~clk;

  mrc_diversity_combiner_top DUT (.*);

  // Sink with random stall bursts.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        sb.check_result('{combined_latent, combined_conf, no_weight});
        n_results++;
      end
      if (stall > 0) stall--;
      else if (!quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 6);
      out_ready <= (stall == 0);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    n_writes++;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_conf();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return mrc_pkg::CONF_ONE;
      2: return 16'($urandom_range(32769, 65535));
      3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [15:0] pick_lat();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_snr();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return mrc_pkg::SNR_ONE;
      3: return 32'($urandom_range(1, 255));
      default: return $urandom;
    endcase
  endfunction

  // Drive one symbol, optionally idling first; valid is held across back-to-back transfers.
  task automatic send(mrc_pkg::word_arr_t lat, mrc_pkg::word_arr_t conf, bit gaps);
    if (gaps && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    {lat_b3, lat_b2, lat_b1, lat_b0} <= lat;
    {conf_b3, conf_b2, conf_b1, conf_b0} <= conf;
    do @(posedge clk); while (!in_ready);
    sb.note_symbol(lat, conf);
    n_symbols++;
  endtask

  task automatic send_random();
    mrc_pkg::word_arr_t l, c;
    for (int i = 0; i < mrc_pkg::BRANCHES; i++) begin
      l[i] = pick_lat();
      c[i] = pick_conf();
    end
    send(l, c, 1);
  endtask

  task automatic finish_burst();
    in_valid <= 0;
    @(posedge clk);
    drain();
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes at reset settings, zero weight, confidence above one.
    send('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
         '{mrc_pkg::CONF_ONE, mrc_pkg::CONF_ONE, mrc_pkg::CONF_ONE, mrc_pkg::CONF_ONE}, 0);
    send('{16'h8000, 16'h8000, 16'h8000, 16'h8000},
         '{mrc_pkg::CONF_ONE, mrc_pkg::CONF_ONE, mrc_pkg::CONF_ONE, mrc_pkg::CONF_ONE}, 0);
    send('{16'h1234, 16'h1234, 16'h7fff, 16'h8000}, '{16'd0, 16'd0, 16'd0, 16'd0}, 0);
    send('{16'h0, 16'h0, 16'h7fff, 16'h8000}, '{16'hffff, 16'hffff, 16'hffff, 16'h8001}, 0);
    send('{16'h0, 16'h0, 16'h0001, 16'hffff}, '{16'd1, 16'd1, 16'd1, 16'd1}, 0);
    finish_burst();
    // Single lane and lane count zero pass lane 0 through.
    write_reg(mrc_pkg::REG_BRANCHES, 3'd1);
    send('{16'h5555, 16'h5555, 16'h5555, 16'h8000}, '{16'd7, 16'd7, 16'd7, 16'hffff}, 0);
    finish_burst();
    write_reg(mrc_pkg::REG_BRANCHES, 3'd0);
    send('{16'h5555, 16'h5555, 16'h5555, 16'h7fff}, '{16'd7, 16'd7, 16'd7, 16'd0}, 0);
    finish_burst();
    // All SNRs zero fall back to one; lane count above four clamps.
    write_reg(mrc_pkg::REG_BRANCHES, 3'd7);
    for (int i = 0; i < mrc_pkg::BRANCHES; i++)
      write_reg(mrc_pkg::REG_SNR_B0 + 3'(i), 32'd0);
    send('{16'h7fff, 16'h8000, 16'h0100, 16'h0200},
         '{mrc_pkg::CONF_ONE, 16'd100, 16'd0, mrc_pkg::CONF_ONE}, 0);
    finish_burst();
    for (int i = 0; i < mrc_pkg::BRANCHES; i++)
      write_reg(mrc_pkg::REG_SNR_B0 + 3'(i), 32'hffff_ffff);
    send('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
         '{mrc_pkg::CONF_ONE, mrc_pkg::CONF_ONE, mrc_pkg::CONF_ONE, mrc_pkg::CONF_ONE}, 0);
    send('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff},
         '{16'd1, mrc_pkg::CONF_ONE, 16'd3, 16'd9}, 0);
    finish_burst();
    write_reg(3'd5, 32'hdead_beef);
    write_reg(3'd7, 32'd1);
    write_reg(mrc_pkg::REG_BRANCHES, 3'd2);
    write_reg(mrc_pkg::REG_SNR_B0, 32'd1);
    write_reg(mrc_pkg::REG_SNR_B0 + 3'd1, 32'hffff_ffff);
    send('{16'h0, 16'h0, 16'h7fff, 16'h8000},
         '{16'd0, 16'd0, mrc_pkg::CONF_ONE, mrc_pkg::CONF_ONE}, 0);
    send('{16'h0, 16'h0, 16'h7fff, 16'h8000}, '{16'd0, 16'd0, 16'd1, mrc_pkg::CONF_ONE}, 0);
    finish_burst();

    // Random phases with fresh settings between them.
    for (int p = 0; p < 24; p++) begin
      write_reg(mrc_pkg::REG_BRANCHES, 3'($urandom_range(0, 7)));
      for (int i = 0; i < mrc_pkg::BRANCHES; i++)
        write_reg(mrc_pkg::REG_SNR_B0 + 3'(i), pick_snr());
      if (p == 20) quiet = 1;
      repeat (80) send_random();
      finish_burst();
    end

    in_valid <= 0;
    drain();
    $display("Covered %0d symbols, %0d results, %0d register writes over all lane counts,",
             n_symbols, n_results, n_writes);
    $display("zero and full-scale SNRs, zero weight, and confidences above one.");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== mrc_diversity_combiner_top.f =====
+incdir+sv
sv/mrc_pkg.sv
sv/mrc_front.sv
sv/mrc_divide.sv
sv/mrc_sqrt.sv
sv/mrc_diversity_combiner_top.sv
sv/mrc_checker.sv
dv/tb_mrc_diversity_combiner_top.sv
